/* hdl/t2dta_pkg.sv */
`timescale 1ns / 1ps

package t2dta_pkg;

    // Widest texture row the block supports, in blocks
    localparam int MAX_WIDTH_BLOCKS = 8192;

    localparam int IDX_W          = 26;
    localparam int WREG_W         = 14;
    localparam int PL_W           = 3;
    localparam int SURF_W         = 31;
    localparam int COORD_W        = 13;
    localparam int OFF_W          = 30;
    localparam int PITCH_LOG2_MAX = 4;
    localparam int CFG_IDX_W      = 2;

    localparam int WEFF_W = $clog2(MAX_WIDTH_BLOCKS + 1);
    localparam int MPR_MAX = MAX_WIDTH_BLOCKS / 32;
    localparam int MPR_W   = $clog2(MPR_MAX + 1);
    localparam int REM_W   = $clog2(MPR_MAX);

    // Byte index, tile-compacted index and macro-tile number
    localparam int OB_W = IDX_W + PITCH_LOG2_MAX;
    localparam int OT_W = OB_W - 3;
    localparam int OM_W = IDX_W - 10;

    localparam int DIV_BITS = 4;
    localparam int DIV_STG  = (OM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int N_STG    = DIV_STG + 3;

    localparam int X_W    = REM_W + 5;
    localparam int Y_W    = OM_W + 5;
    localparam int PROD_W = Y_W + WEFF_W + 1;
    localparam int DST_W  = PROD_W + PITCH_LOG2_MAX;

    localparam int S_TDATA_W = ((IDX_W + 7) / 8) * 8;
    localparam int M_FLDS_W  = 2 * COORD_W + 2 * OFF_W;
    localparam int M_TDATA_W = ((M_FLDS_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_PITCH   = 2'd1,
        CFG_SURFACE = 2'd2
    } t_cfg_idx;

    // Front and divider stages
    typedef struct packed {
        logic [OM_W-1:0]  num;
        logic [REM_W-1:0] rem;
        logic [1:0]       tx;
        logic [2:0]       ux;
        logic [1:0]       ty;
        logic [2:0]       ylo;
        logic [OFF_W-1:0] src;
        logic             src_ok;
    } t_item;

    // Multiply stage
    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [PROD_W-1:0] acc;
        logic [OFF_W-1:0]  src;
        logic              src_ok;
    } t_prod;

    // Output stage
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [OFF_W-1:0]   src;
        logic [OFF_W-1:0]   dst;
        logic               ok;
    } t_res;

endpackage

/* hdl/t2dta_detile.sv */
`timescale 1ns / 1ps

module t2dta_detile import t2dta_pkg::*; (
    input  logic [IDX_W-1:0]  i_block_offset,
    input  logic [PL_W-1:0]   i_pitch_log2,
    input  logic [SURF_W-1:0] i_surface,
    output t_item             o_item
);

    logic [OB_W-1:0]   ob;
    logic [OT_W-1:0]   ot;
    logic [OT_W-1:0]   ot_sh;
    logic [OT_W-1:0]   om_full;
    logic [OT_W-1:0]   v;
    logic [OT_W-1:0]   v_sh;
    logic [10:0]       ymask;
    logic [10:0]       s;
    logic [10:0]       s_sh;
    logic [3:0]        lb4;
    logic [OFF_W:0]    src_end;

    always_comb begin
        lb4 = {1'b0, i_pitch_log2};
        ob  = OB_W'(i_block_offset) << i_pitch_log2;
        // Compact out byte bits 11 and 7:6, which select the tile inside a macro tile
        ot      = {ob[OB_W-1:12], ob[10:8], ob[5:0]};
        ot_sh   = ot >> i_pitch_log2;
        om_full = ot >> (lb4 + 4'd7);

        v    = {1'b0, ot[OT_W-1:5], ot[3:0]};
        v_sh = v >> i_pitch_log2;

        ymask = ((11'd64 << i_pitch_log2) - 11'd1) & ~11'h01F;
        s     = (ot[10:0] & ymask) + {6'b0, ot[3:0], 1'b0};
        s_sh  = s >> (lb4 + 4'd3);

        src_end = {1'b0, ob} + ((OFF_W+1)'(1) << i_pitch_log2);

        o_item.num    = om_full[OM_W-1:0];
        o_item.rem    = '0;
        o_item.tx     = {ot_sh[6], 1'b0} + ob[7:6];
        o_item.ux     = v_sh[2:0];
        o_item.ty     = {ob[11], ot_sh[6]};
        o_item.ylo    = {s_sh[2:1], ot[4]};
        o_item.src    = ob;
        o_item.src_ok = (src_end <= i_surface);
    end

endmodule

/* hdl/t2dta_div_step.sv */
`timescale 1ns / 1ps

module t2dta_div_step import t2dta_pkg::*; (
    input  logic [REM_W-1:0] i_rem,
    input  logic [OM_W-1:0]  i_num,
    input  logic [MPR_W-1:0] i_divisor,
    output logic [REM_W-1:0] o_rem,
    output logic [OM_W-1:0]  o_num
);

    logic [REM_W:0]   t;
    logic [REM_W:0]   d;
    logic [REM_W-1:0] rem;
    logic [OM_W-1:0]  num;

    // Restoring division, quotient bits shift in where dividend bits leave
    always_comb begin
        d   = (REM_W+1)'(i_divisor);
        rem = i_rem;
        num = i_num;
        t   = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            t   = {rem, num[OM_W-1]};
            num = {num[OM_W-2:0], 1'b0};
            if (t >= d) begin
                t      = t - d;
                num[0] = 1'b1;
            end
            rem = t[REM_W-1:0];
        end
        o_rem = rem;
        o_num = num;
    end

endmodule

/* hdl/tiled_2d_texture_address.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Payload
// s         in         i_s_tvalid / o_s_tready       i_s_tdata: block_offset
// m         out        o_m_tvalid / i_m_tready       o_m_tdata, o_m_tuser: copy_valid
// cfg       in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One word per cycle while the output takes words; seven stages: detile, four divide
// stages (16 quotient bits, 4 per stage), multiply-add, shift/compare.
// A full stage holds while the next cannot take; input is still taken under an output
// stall while any stage is empty.
// Synchronous active-low reset empties the pipe and sets width 1, pitch code 2, size 0.

module tiled_2d_texture_address import t2dta_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [25:0] block_offset
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // [12:0] tiled_x, [25:13] tiled_y,
                                               // [55:26] src_byte_offset,
                                               // [85:56] dest_byte_offset
    output logic                  o_m_tuser,   // [0] copy_valid
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SURF_W-1:0]     i_cfg_data
);

    logic [WREG_W-1:0] r_width;
    logic [PL_W-1:0]   r_pitch_log2;
    logic [SURF_W-1:0] r_surface;

    logic [WEFF_W-1:0] w_eff;
    logic [WEFF_W:0]   w_round;
    logic [MPR_W-1:0]  mpr;
    logic [PL_W-1:0]   lb;

    logic [N_STG-1:0]  r_vld;
    logic [N_STG-1:0]  en;
    t_item             r_item [0:DIV_STG];
    t_item             n_item [1:DIV_STG];
    t_item             front;
    t_prod             r_prod;
    t_prod             n_prod;
    t_res              r_res;
    t_res              n_res;

    logic [REM_W-1:0]  div_rem [0:DIV_STG-1];
    logic [OM_W-1:0]   div_num [0:DIV_STG-1];

    logic [PROD_W-1:0] mul;
    logic [DST_W-1:0]  dst_full;
    logic [DST_W:0]    dst_end;

    // Configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WREG_W'(1);
            r_pitch_log2 <= PL_W'(2);
            r_surface    <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:   r_width      <= i_cfg_data[WREG_W-1:0];
                CFG_PITCH:   r_pitch_log2 <= i_cfg_data[PL_W-1:0];
                CFG_SURFACE: r_surface    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            w_eff = WEFF_W'(1);
        end else if (WEFF_W'(r_width) > WEFF_W'(MAX_WIDTH_BLOCKS)) begin
            w_eff = WEFF_W'(MAX_WIDTH_BLOCKS);
        end else begin
            w_eff = WEFF_W'(r_width);
        end
        w_round = {1'b0, w_eff} + (WEFF_W+1)'(31);
        mpr     = MPR_W'(w_round >> 5);
        lb      = (r_pitch_log2 > PL_W'(PITCH_LOG2_MAX)) ? PL_W'(PITCH_LOG2_MAX) : r_pitch_log2;
    end

    // Stage enables: advance a stage when it is empty or the next one advances
    always_comb begin
        en[N_STG-1] = !r_vld[N_STG-1] || i_m_tready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    t2dta_detile u_detile (
        .i_block_offset (i_s_tdata[IDX_W-1:0]),
        .i_pitch_log2   (lb),
        .i_surface      (r_surface),
        .o_item         (front)
    );

    genvar g;
    generate
        for (g = 0; g < DIV_STG; g++) begin : g_div
            t2dta_div_step u_div_step (
                .i_rem     (r_item[g].rem),
                .i_num     (r_item[g].num),
                .i_divisor (mpr),
                .o_rem     (div_rem[g]),
                .o_num     (div_num[g])
            );
        end
    endgenerate

    always_comb begin
        for (int k = 0; k < DIV_STG; k++) begin
            n_item[k+1]     = r_item[k];
            n_item[k+1].rem = div_rem[k];
            n_item[k+1].num = div_num[k];
        end
    end

    // Column is {macro col, tile col, micro col}; row likewise, so no adds are needed
    always_comb begin
        n_prod.x      = {r_item[DIV_STG].rem, r_item[DIV_STG].tx, r_item[DIV_STG].ux};
        n_prod.y      = {r_item[DIV_STG].num, r_item[DIV_STG].ty, r_item[DIV_STG].ylo};
        mul           = PROD_W'(n_prod.y) * PROD_W'(w_eff);
        n_prod.acc    = mul + PROD_W'(n_prod.x);
        n_prod.src    = r_item[DIV_STG].src;
        n_prod.src_ok = r_item[DIV_STG].src_ok;
    end

    always_comb begin
        dst_full  = DST_W'(r_prod.acc) << lb;
        dst_end   = {1'b0, dst_full} + ((DST_W+1)'(1) << lb);
        n_res.x   = r_prod.x[COORD_W-1:0];
        n_res.y   = r_prod.y[COORD_W-1:0];
        n_res.src = r_prod.src;
        n_res.dst = dst_full[OFF_W-1:0];
        n_res.ok  = r_prod.src_ok && (dst_end <= (DST_W+1)'(r_surface));
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_item[0] <= front;
        end
        for (int k = 0; k < DIV_STG; k++) begin
            if (en[k+1]) begin
                r_item[k+1] <= n_item[k+1];
            end
        end
        if (en[DIV_STG+1]) begin
            r_prod <= n_prod;
        end
        if (en[N_STG-1]) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_vld[N_STG-1];
    assign o_m_tdata  = M_TDATA_W'({r_res.dst, r_res.src, r_res.y, r_res.x});
    assign o_m_tuser  = r_res.ok;

`ifndef SYNTHESIS
    // An empty output register frees the whole pipe
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output stage");

    // An accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted word lost at first stage");

    // Accepting under an output stall needs a bubble somewhere
    a_bubble_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && o_s_tready) |-> ($countones(r_vld) < N_STG))
        else $error("input taken into a full stalled pipe");
`endif

endmodule

/* bench/tb_tiled_2d_texture_address.sv */
`timescale 1ns / 1ps

module tb_tiled_2d_texture_address;
    import t2dta_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [OFF_W-1:0]   src_off;
        logic [OFF_W-1:0]   dst_off;
        logic               fits;
    } t_texel_addr;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_WIDTH;
    logic [SURF_W-1:0]    i_cfg_data = '0;

    // Shadow copy of the register file, updated as each write is taken
    logic [WREG_W-1:0] width_reg = 14'd1;
    logic [PL_W-1:0]   pitch_reg = 3'd2;
    logic [SURF_W-1:0] surface_reg = '0;

    t_texel_addr pending_addr_q[$];
    int          mismatches = 0;
    int          hold_cycles = 0;
    bit          idle_on = 1'b1;

    tiled_2d_texture_address dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_800_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_texel_addr detile_address(input logic [IDX_W-1:0] blk);
        bit [63:0]   idx, w, lb, pitch, mpr, ob, ot, om, mx, tx, ux, x;
        bit [63:0]   my, ty, ymask, uy, y, src, dst, surf;
        t_texel_addr r;
        idx = blk;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH_BLOCKS) w = MAX_WIDTH_BLOCKS;
        lb = pitch_reg;
        if (lb > PITCH_LOG2_MAX) lb = PITCH_LOG2_MAX;
        pitch = 64'd1 << lb;
        surf = surface_reg;
        mpr = ((w + 31) & ~64'h1F) >> 5;

        ob = idx << lb;
        ot = ((ob & ~64'hFFF) >> 3) + ((ob & 64'h700) >> 2) + (ob & 64'h3F);
        om = ot >> (7 + lb);

        mx = (om % mpr) << 2;
        tx = (((ot >> (5 + lb)) & 64'd2) + (ob >> 6)) & 64'd3;
        ux = ((((ot >> 1) & ~64'hF) + (ot & 64'hF)) & ((pitch << 3) - 1)) >> lb;
        x = ((mx + tx) << 3) + ux;

        my = (om / mpr) << 2;
        ty = ((ot >> (6 + lb)) & 64'd1) + ((ob & 64'h800) >> 10);
        ymask = ((pitch << 6) - 1) & ~64'h1F;
        uy = (((ot & ymask) + ((ot & 64'hF) << 1)) >> (3 + lb)) & ~64'h1;
        y = ((my + ty) << 3) + uy + ((ot & 64'h10) >> 4);

        src = idx * pitch;
        dst = (y * w + x) * pitch;
        r.col = x[COORD_W-1:0];
        r.row = y[COORD_W-1:0];
        r.src_off = src[OFF_W-1:0];
        r.dst_off = dst[OFF_W-1:0];
        // judge the fit on the full offsets, not the truncated ones
        r.fits = (src + pitch <= surf) && (dst + pitch <= surf);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < 100)
            $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= !(idle_on && $urandom_range(0, 99) < 10);
            end
        end
    end

    initial begin
        t_texel_addr got, want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.col = o_m_tdata[12:0];
                got.row = o_m_tdata[25:13];
                got.src_off = o_m_tdata[55:26];
                got.dst_off = o_m_tdata[85:56];
                got.fits = o_m_tuser;
                if (pending_addr_q.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = pending_addr_q.pop_front();
                    if (got.col !== want.col)
                        report_mismatch("tiled_x", longint'(got.col), longint'(want.col));
                    if (got.row !== want.row)
                        report_mismatch("tiled_y", longint'(got.row), longint'(want.row));
                    if (got.src_off !== want.src_off)
                        report_mismatch("src_byte_offset", longint'(got.src_off),
                                        longint'(want.src_off));
                    if (got.dst_off !== want.dst_off)
                        report_mismatch("dest_byte_offset", longint'(got.dst_off),
                                        longint'(want.dst_off));
                    if (got.fits !== want.fits)
                        report_mismatch("copy_valid", longint'(got.fits), longint'(want.fits));
                end
            end
        end
    end

    // Offer one word and hold it until taken
    task automatic send_block(input logic [IDX_W-1:0] blk);
        if (idle_on && $urandom_range(0, 99) < 5) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= S_TDATA_W'(blk);
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_addr_q.push_back(detile_address(blk));
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_addr_q.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [SURF_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_WIDTH:   width_reg = value[WREG_W-1:0];
            CFG_PITCH:   pitch_reg = value[PL_W-1:0];
            CFG_SURFACE: surface_reg = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [WREG_W-1:0] w, input logic [PL_W-1:0] p,
                             input logic [SURF_W-1:0] s);
        wait_drained();
        write_reg(CFG_WIDTH, SURF_W'(w));
        write_reg(CFG_PITCH, SURF_W'(p));
        write_reg(CFG_SURFACE, s);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_values();
        send_block('0);
        send_block(26'h3FFFFFF);
        send_block(26'h1555555);
    endtask

    task automatic test_field_extremes();
        configure(14'd8192, 3'd4, 31'h7FFFFFFF);
        send_block('0);
        send_block(26'h3FFFFFF);
        send_block(26'h2AAAAAA);
        configure(14'd1, 3'd0, 31'h40000000);
        send_block('0);
        send_block(26'h3FFFFFF);
        send_block(26'd1023);
    endtask

    task automatic test_special_cases();
        // zero width behaves as one block wide
        configure(14'd0, 3'd2, 31'd4096);
        send_block('0);
        send_block(26'd5);
        send_block(26'd1023);
        // width and pitch code both saturate
        configure(14'h3FFF, 3'd7, 31'h7FFFFFFF);
        send_block('0);
        send_block(26'h3FFFFFF);
        configure(14'd9000, 3'd5, 31'h7FFFFFFF);
        send_block(26'h0ABCDEF);
        configure(14'd8191, 3'd6, 31'd0);
        send_block(26'h1234567);
        // copy that ends exactly at the surface edge, then one past it
        configure(14'd64, 3'd2, 31'd4);
        send_block('0);
        send_block(26'd1);
    endtask

    task automatic random_config();
        logic [WREG_W-1:0] w;
        logic [SURF_W-1:0] s;
        case ($urandom_range(0, 4))
            0: w = WREG_W'($urandom_range(0, 16383));
            1: w = WREG_W'($urandom_range(1, 64));
            2: w = WREG_W'($urandom_range(31, 33));
            3: w = 14'd8192;
            default: w = WREG_W'($urandom_range(1, 1024));
        endcase
        case ($urandom_range(0, 3))
            0: s = 31'h7FFFFFFF;
            1: s = SURF_W'($urandom());
            2: s = SURF_W'($urandom_range(0, 1 << 22));
            default: s = '0;
        endcase
        configure(w, PL_W'($urandom_range(0, 7)), s);
    endtask

    function automatic logic [IDX_W-1:0] random_block();
        if ($urandom_range(0, 1)) return IDX_W'($urandom());
        return IDX_W'($urandom_range(0, 1 << 16));
    endfunction

    task automatic test_random_stream();
        for (int phase = 0; phase < 15; phase++) begin
            // first phases run flat out, with no idling on either side
            idle_on = (phase >= 3);
            if (phase == 0) configure(14'd8192, 3'd4, 31'h7FFFFFFF);
            else if (phase == 1) configure(14'd1, 3'd0, 31'd0);
            else random_config();
            repeat ($urandom_range(40, 70)) send_block(random_block());
        end
    endtask

    task automatic test_backpressure();
        configure(14'd100, 3'd3, 31'h7FFFFFFF);
        idle_on = 1'b0;
        hold_cycles = 300;
        repeat (60) send_block(random_block());
        idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        configure(14'd40, 3'd1, 31'd65536);
        repeat (15) send_block(random_block());
        wait_drained();
        repeat (15) send_block(random_block());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_field_extremes();
        test_special_cases();
        test_backpressure();
        test_drain_pause();
        test_random_stream();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/t2dta_pkg.sv
hdl/t2dta_detile.sv
hdl/t2dta_div_step.sv
hdl/tiled_2d_texture_address.sv
bench/tb_tiled_2d_texture_address.sv
